[hdl/bda_pkg.sv]
package bda_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_PUSH    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_FIRST_REPEAT = 2'd1,
        REG_REPEAT       = 2'd2
    } t_reg_idx;

    localparam int unsigned TIME_W        = 16;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned NUM_BUTTONS   = 2;

    localparam logic [TIME_W-1:0] DEBOUNCE_RST     = 16'd20;
    localparam logic [TIME_W-1:0] FIRST_REPEAT_RST = 16'd500;
    localparam logic [TIME_W-1:0] REPEAT_RST       = 16'd100;

endpackage

[hdl/bda_in_if.sv]
interface bda_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       button;
    logic       pin_pushed;
    logic       repeat_enable;

    modport source (output valid, kind, button, pin_pushed, repeat_enable, input ready);
    modport sink   (input valid, kind, button, pin_pushed, repeat_enable, output ready);
endinterface

[hdl/bda_out_if.sv]
interface bda_out_if;
    logic valid;
    logic ready;
    logic push_event;
    logic release_event;

    modport source (output valid, push_event, release_event, input ready);
    modport sink   (input valid, push_event, release_event, output ready);
endinterface

[hdl/button_debounce_autorepeat.sv]
// Each accepted request passes through the input register and then the result register.
// Throughput: one request per cycle while the result is taken; each request is one compare
// and reload or decrement of a single button's timer, done between input and result register.
// Reset (synchronous, active low): timers and repeat flags cleared, registers back to
// debounce 20, first repeat 500, repeat 100 ticks; both pipeline stages empty.
module button_debounce_autorepeat #(
    parameter int unsigned NUM_BUTTONS = bda_pkg::NUM_BUTTONS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    bda_in_if.sink                               i_in,
    bda_out_if.source                            o_out,
    input  logic                                 i_cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bda_pkg::TIME_W-1:0]           i_cfg_data
);

    // The button field is one bit, so at most two buttons are reachable
    localparam int unsigned NUM_ST = (NUM_BUTTONS < 2) ? NUM_BUTTONS : 2;
    localparam int unsigned IDX_W  = 1;
    localparam int unsigned TW     = bda_pkg::TIME_W;

    // Configuration registers
    logic [TW-1:0] r_debounce;
    logic [TW-1:0] r_first_repeat;
    logic [TW-1:0] r_repeat;

    // Per-button state
    logic [TW-1:0] r_timer [NUM_ST];
    logic          r_rep   [NUM_ST];

    // Input register
    logic       r_in_vld;
    logic [1:0] r_kind;
    logic       r_btn;
    logic       r_pin;
    logic       r_rep_en;

    // Result register
    logic r_out_vld;
    logic r_push;
    logic r_rel;

    logic             out_free;
    logic             fire;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [TW-1:0]    cur_t;
    logic             cur_rep;
    logic [TW-1:0]    n_timer;
    logic             n_rep;
    logic             n_push;
    logic             n_rel;

    assign out_free   = !r_out_vld || o_out.ready;
    assign fire       = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;

    assign o_out.valid         = r_out_vld;
    assign o_out.push_event    = r_push;
    assign o_out.release_event = r_rel;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce     <= bda_pkg::DEBOUNCE_RST;
            r_first_repeat <= bda_pkg::FIRST_REPEAT_RST;
            r_repeat       <= bda_pkg::REPEAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bda_pkg::REG_DEBOUNCE:     r_debounce     <= i_cfg_data;
                bda_pkg::REG_FIRST_REPEAT: r_first_repeat <= i_cfg_data;
                bda_pkg::REG_REPEAT:       r_repeat       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_kind   <= i_in.kind;
            r_btn    <= i_in.button;
            r_pin    <= i_in.pin_pushed;
            r_rep_en <= i_in.repeat_enable;
        end
    end

    // Select the button's state
    assign in_range = (7'(r_btn) < 7'(NUM_BUTTONS));
    assign idx      = in_range ? IDX_W'(r_btn) : '0;
    assign cur_t    = r_timer[idx];
    assign cur_rep  = r_rep[idx];

    // Decrement, reload or fire
    always_comb begin
        n_timer = cur_t;
        n_rep   = cur_rep;
        n_push  = 1'b0;
        n_rel   = 1'b0;
        if (in_range) begin
            case (r_kind)
                bda_pkg::KIND_TICK: begin
                    if (cur_t != '0) begin
                        n_timer = cur_t - TW'(1);
                    end
                end
                bda_pkg::KIND_PUSH: begin
                    if (r_pin) begin
                        if (cur_t == TW'(1)) begin
                            n_push = 1'b1;
                            if (r_rep_en) begin
                                if (!cur_rep) begin
                                    n_timer = r_first_repeat;
                                    n_rep   = 1'b1;
                                end else begin
                                    n_timer = r_repeat;
                                end
                            end else begin
                                n_timer = '0;
                            end
                        end
                    end else begin
                        n_timer = r_debounce;
                        n_rep   = 1'b0;
                    end
                end
                bda_pkg::KIND_RELEASE: begin
                    if (r_pin) begin
                        n_timer = r_debounce;
                    end else if (cur_t == TW'(1)) begin
                        n_rel   = 1'b1;
                        n_timer = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Update per-button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_ST; b++) begin
                r_timer[b] <= '0;
                r_rep[b]   <= 1'b0;
            end
        end else if (fire && in_range) begin
            r_timer[idx] <= n_timer;
            r_rep[idx]   <= n_rep;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_push <= n_push;
            r_rel  <= n_rel;
        end
    end

endmodule

[hdl/bda_checker.sv]
module bda_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_push_event,
    input logic i_release_event
);

    // One request never fires both events
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_push_event && i_release_event))
        else $error("push and release events fired together");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_push_event) && $stable(i_release_event)))
        else $error("stalled result changed");

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_push_event    (o_out.push_event),
    .i_release_event (o_out.release_event)
);

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  KIND_UNUSED     = 2'd3;
    localparam int unsigned TW              = bda_pkg::TIME_W;
    localparam int unsigned STALL_LIMIT     = 1000;
    localparam int unsigned HOLD_OFF_CYCLES = 120;
    localparam int unsigned PHASE_REQUESTS  = 214;
    localparam int unsigned NUM_PHASES      = 9;
    localparam int unsigned MAX_PRINTED     = 40;

    // Timer settings, idling and stalling per random phase, extremes included
    localparam int unsigned PH_DEBOUNCE [NUM_PHASES] = '{2, 1, 0, 4, 65535, 3, 1, 5, 2};
    localparam int unsigned PH_FIRST    [NUM_PHASES] = '{3, 1, 0, 6, 65535, 2, 2, 8, 0};
    localparam int unsigned PH_REPEAT   [NUM_PHASES] = '{1, 1, 0, 2, 65535, 0, 65535, 3, 65535};
    localparam int unsigned PH_TX_IDLE  [NUM_PHASES] = '{0, 61, 0, 27, 0, 61, 0, 27, 0};
    localparam int unsigned PH_RX_STALL [NUM_PHASES] = '{0, 0, 61, 27, 0, 0, 61, 27, 0};

    typedef struct packed {
        logic push_ev;
        logic rel_ev;
    } t_button_events;

    // Track per-button timers and compare the events the block reports
    class debounce_scoreboard;
        logic [TW-1:0]     debounce_ticks;
        logic [TW-1:0]     first_repeat_ticks;
        logic [TW-1:0]     repeat_ticks;
        logic [TW-1:0]     down_count [bda_pkg::NUM_BUTTONS];
        bit                auto_repeat [bda_pkg::NUM_BUTTONS];
        t_button_events    expected_events [$];
        int unsigned       errors;

        function new();
            debounce_ticks     = bda_pkg::DEBOUNCE_RST;
            first_repeat_ticks = bda_pkg::FIRST_REPEAT_RST;
            repeat_ticks       = bda_pkg::REPEAT_RST;
            foreach (down_count[b]) begin
                down_count[b]  = '0;
                auto_repeat[b] = 1'b0;
            end
            errors = 0;
        endfunction

        function void set_timers(logic [TW-1:0] deb, logic [TW-1:0] first,
                                 logic [TW-1:0] rep);
            debounce_ticks     = deb;
            first_repeat_ticks = first;
            repeat_ticks       = rep;
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        // Apply one request to the button state and queue the events it fires
        function void note_request(logic [1:0] kind, logic btn, logic pressed, logic rep_on);
            t_button_events ev;
            ev = '0;
            if (btn < bda_pkg::NUM_BUTTONS) begin
                case (kind)
                    bda_pkg::KIND_TICK: begin
                        if (down_count[btn] != 0)
                            down_count[btn] = down_count[btn] - 1'b1;
                    end
                    bda_pkg::KIND_PUSH: begin
                        if (!pressed) begin
                            down_count[btn]  = debounce_ticks;
                            auto_repeat[btn] = 1'b0;
                        end else if (down_count[btn] == 1) begin
                            ev.push_ev = 1'b1;
                            if (!rep_on) begin
                                down_count[btn] = '0;
                            end else if (!auto_repeat[btn]) begin
                                down_count[btn]  = first_repeat_ticks;
                                auto_repeat[btn] = 1'b1;
                            end else begin
                                down_count[btn] = repeat_ticks;
                            end
                        end
                    end
                    bda_pkg::KIND_RELEASE: begin
                        if (pressed) begin
                            down_count[btn] = debounce_ticks;
                        end else if (down_count[btn] == 1) begin
                            ev.rel_ev       = 1'b1;
                            down_count[btn] = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            expected_events.push_back(ev);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result with the oldest outstanding request
        task check_result(logic push_ev, logic rel_ev);
            t_button_events want;
            if (expected_events.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            want = expected_events.pop_front();
            if (push_ev !== want.push_ev)
                report($sformatf("push_event %b, expected %b", push_ev, want.push_ev));
            if (rel_ev !== want.rel_ev)
                report($sformatf("release_event %b, expected %b", rel_ev, want.rel_ev));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bda_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [TW-1:0]                 i_cfg_data;

    bda_in_if  in_if ();
    bda_out_if out_if ();

    debounce_scoreboard sb;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_cycles  = 0;
    int unsigned quiet_cycles = 0;

    button_debounce_autorepeat u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Drive result ready: long hold-off when asked, else random stalls
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Observe handshakes, feed the scoreboard and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_request(in_if.kind, in_if.button, in_if.pin_pushed,
                                in_if.repeat_enable);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.push_event, out_if.release_event);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Offer one request, idling first at the current rate, and hold until taken
    task automatic send_request(logic [1:0] kind, logic btn, logic pressed, logic rep_on);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.kind          <= kind;
        in_if.button        <= btn;
        in_if.pin_pushed    <= pressed;
        in_if.repeat_enable <= rep_on;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic wait_results_drained();
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three timer registers on consecutive cycles
    task automatic program_timers(logic [TW-1:0] deb, logic [TW-1:0] first,
                                  logic [TW-1:0] rep);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bda_pkg::REG_DEBOUNCE;
        i_cfg_data <= deb;
        @(posedge i_clk);
        i_cfg_idx  <= bda_pkg::REG_FIRST_REPEAT;
        i_cfg_data <= first;
        @(posedge i_clk);
        i_cfg_idx  <= bda_pkg::REG_REPEAT;
        i_cfg_data <= rep;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_timers(deb, first, rep);
    endtask

    // Emulate held and released buttons with some contact bounce and noise
    task automatic run_phase(int unsigned count, int unsigned tx_pct, int unsigned rx_pct,
                             bit hold_off);
        bit          held [bda_pkg::NUM_BUTTONS];
        logic        btn;
        logic        pressed;
        logic [1:0]  kind;
        int unsigned roll;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        foreach (held[b])
            held[b] = 1'b0;
        for (int unsigned i = 0; i < count; i++) begin
            if (hold_off && i == count / 3)
                hold_cycles = HOLD_OFF_CYCLES;
            btn = 1'($urandom_range(bda_pkg::NUM_BUTTONS - 1));
            if ($urandom_range(15) == 0)
                held[btn] = !held[btn];
            pressed = held[btn];
            if ($urandom_range(19) == 0)
                pressed = !pressed;
            roll = $urandom_range(99);
            if (roll < 50)
                kind = bda_pkg::KIND_TICK;
            else if (roll < 95)
                kind = (held[btn] ^ ($urandom_range(4) == 0)) ? bda_pkg::KIND_PUSH
                                                               : bda_pkg::KIND_RELEASE;
            else
                kind = KIND_UNUSED;
            send_request(kind, btn, pressed, $urandom_range(3) != 0);
        end
        in_if.valid <= 1'b0;
        wait_results_drained();
    endtask

    initial begin
        sb                  = new();
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = bda_pkg::REG_DEBOUNCE;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.kind          = bda_pkg::KIND_TICK;
        in_if.button        = 1'b0;
        in_if.pin_pushed    = 1'b0;
        in_if.repeat_enable = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle timers, unused kind, reloads, then a full debounce at reset timing
        send_request(bda_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0);
        send_request(KIND_UNUSED, 1'b1, 1'b1, 1'b1);
        send_request(bda_pkg::KIND_PUSH, 1'b0, 1'b1, 1'b1);
        send_request(bda_pkg::KIND_RELEASE, 1'b1, 1'b1, 1'b0);
        send_request(bda_pkg::KIND_RELEASE, 1'b1, 1'b0, 1'b0);
        send_request(bda_pkg::KIND_PUSH, 1'b0, 1'b0, 1'b0);
        repeat (bda_pkg::DEBOUNCE_RST - 1)
            send_request(bda_pkg::KIND_TICK, 1'b0, 1'b1, 1'b1);
        send_request(bda_pkg::KIND_PUSH, 1'b0, 1'b1, 1'b1);
        in_if.valid <= 1'b0;
        wait_results_drained();

        // Random phases, one timer setting each
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            program_timers(TW'(PH_DEBOUNCE[p]), TW'(PH_FIRST[p]), TW'(PH_REPEAT[p]));
            run_phase(PHASE_REQUESTS, PH_TX_IDLE[p], PH_RX_STALL[p], p == 0);
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
